FILE: rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and codes of the configurable text tokenizer.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int SET_SLOTS_DEF   = 8;
  localparam int COMMENT_MAX_DEF = 8;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLITTER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_OPEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_CLOSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP         = 3'd6;

  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_END  = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  localparam logic [1:0] MODE_GAP     = 2'd0;
  localparam logic [1:0] MODE_PLAIN   = 2'd1;
  localparam logic [1:0] MODE_QUOTE   = 2'd2;
  localparam logic [1:0] MODE_COMMENT = 2'd3;

  localparam logic [7:0] ESC_BYTE = 8'h5C;

  localparam int RES_MAX   = 3;
  localparam int RES_CNT_W = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  typedef res_t [RES_MAX-1:0] res_list_t;

  typedef struct packed {
    logic                 valid;
    logic [RES_CNT_W-1:0] cnt;
    res_list_t            list;
  } push_t;

  typedef struct packed {
    logic [CFG_W-1:0] splitter_set;
    logic [CFG_W-1:0] special_set;
    logic [CFG_W-1:0] quote_set;
    logic [CFG_W-1:0] erase_set;
    logic [CFG_W-1:0] comment_open;
    logic [CFG_W-1:0] comment_close;
    logic             strip_quotes;
  } cfg_t;

endpackage

FILE: rtl/ctt_if.sv
// ----------------------------------------------------------------------------
// ctt_if
// Text byte and token result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctt_token_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] token_byte;

  modport source (output valid, output kind, output token_byte, input ready);
  modport sink   (input valid, input kind, input token_byte, output ready);
endinterface

FILE: rtl/ctt_scan.sv
// ----------------------------------------------------------------------------
// ctt_scan
// Lookahead window and scan state; one scan decision per cycle while the output queue has room.
// ----------------------------------------------------------------------------
module ctt_scan #(
  parameter int SET_SLOTS   = ctt_pkg::SET_SLOTS_DEF,
  parameter int COMMENT_MAX = ctt_pkg::COMMENT_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ctt_pkg::cfg_t   cfg,
  ctt_text_if.sink        text_in,
  input  logic            room,
  output ctt_pkg::push_t  push
);

  localparam int FW = $clog2(COMMENT_MAX + 1);
  localparam int IW = (COMMENT_MAX > 1) ? $clog2(COMMENT_MAX) : 1;

  logic [7:0]    win [COMMENT_MAX];
  logic [7:0]    win_next [COMMENT_MAX];
  logic [8*COMMENT_MAX-1:0] wflat;
  logic [FW-1:0] fill, fill_next;
  logic          flush;
  logic [1:0]    mode, mode_next;
  logic [7:0]    oq, oq_next;
  logic          esc, esc_next;
  logic          tne, tne_next;
  logic [FW-1:0] csc, csc_next;

  logic [7:0]    c;
  logic [FW-1:0] len_open, len_close;
  logic          open_here, close_here;
  logic          spl, spc, quo, del;
  logic          work, fin, step, drop, accept;
  ctt_pkg::res_list_t    lst;
  logic [ctt_pkg::RES_CNT_W-1:0] n;

  function automatic logic in_set(input logic [63:0] s, input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SET_SLOTS; i++) begin
      if (s[8*i +: 8] != 8'd0 && s[8*i +: 8] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [FW-1:0] str_len(input logic [63:0] s);
    logic [FW-1:0] k;
    logic          run;
    k   = '0;
    run = 1'b1;
    for (int i = 0; i < COMMENT_MAX; i++) begin
      if (run && s[8*i +: 8] != 8'd0) k = k + 1'b1;
      else run = 1'b0;
    end
    return k;
  endfunction

  function automatic logic match_here(input logic [63:0] s, input logic [FW-1:0] len,
                                      input logic [8*COMMENT_MAX-1:0] w,
                                      input logic [FW-1:0] f);
    logic ok;
    ok = (len != '0) && (len <= f);
    for (int i = 0; i < COMMENT_MAX; i++) begin
      if (FW'(i) < len && w[8*i +: 8] != s[8*i +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  always_comb begin
    for (int i = 0; i < COMMENT_MAX; i++) wflat[8*i +: 8] = win[i];
  end

  assign c          = win[0];
  assign len_open   = str_len(cfg.comment_open);
  assign len_close  = str_len(cfg.comment_close);
  assign open_here  = (len_open != '0) && (len_close != '0) &&
                      match_here(cfg.comment_open, len_open, wflat, fill);
  assign close_here = match_here(cfg.comment_close, len_close, wflat, fill);
  assign spl        = in_set(cfg.splitter_set, c);
  assign spc        = in_set(cfg.special_set, c);
  assign quo        = in_set(cfg.quote_set, c);
  assign del        = in_set(cfg.erase_set, c);

  assign work = (fill >= FW'(COMMENT_MAX)) || (flush && fill != '0);
  assign fin  = flush && fill == '0;
  assign step = work && room;

  // one scan decision
  always_comb begin
    drop      = 1'b0;
    mode_next = mode;
    oq_next   = oq;
    esc_next  = esc;
    tne_next  = tne;
    csc_next  = csc;
    lst       = '0;
    n         = '0;
    if (fin) begin
      if (mode == ctt_pkg::MODE_PLAIN && tne) begin
        lst[n] = '{ctt_pkg::K_END, 8'd0}; n = n + 1'b1;
      end else if (mode == ctt_pkg::MODE_QUOTE) begin
        if (cfg.strip_quotes && esc) begin
          lst[n] = '{ctt_pkg::K_BYTE, ctt_pkg::ESC_BYTE}; n = n + 1'b1;
        end
        lst[n] = '{ctt_pkg::K_ERR, 8'd0}; n = n + 1'b1;
      end
      lst[n] = '{ctt_pkg::K_DONE, 8'd0}; n = n + 1'b1;
    end else if (csc != '0) begin
      csc_next = csc - 1'b1;
      drop     = 1'b1;
    end else begin
      case (mode)
        ctt_pkg::MODE_GAP: begin
          drop = 1'b1;
          if (spl) begin
          end else if (open_here) begin
            csc_next  = len_open - 1'b1;
            mode_next = ctt_pkg::MODE_COMMENT;
          end else if (del) begin
          end else if (spc) begin
            lst[0] = '{ctt_pkg::K_BYTE, c};
            lst[1] = '{ctt_pkg::K_END, 8'd0};
            n = 2'd2;
          end else if (quo) begin
            mode_next = ctt_pkg::MODE_QUOTE;
            oq_next   = c;
            esc_next  = 1'b0;
            if (!cfg.strip_quotes) begin
              lst[0] = '{ctt_pkg::K_BYTE, c}; n = 2'd1;
            end
          end else begin
            mode_next = ctt_pkg::MODE_PLAIN;
            tne_next  = 1'b1;
            lst[0] = '{ctt_pkg::K_BYTE, c}; n = 2'd1;
          end
        end
        ctt_pkg::MODE_PLAIN: begin
          if (spl || spc || quo || open_here) begin
            if (tne) begin
              lst[0] = '{ctt_pkg::K_END, 8'd0}; n = 2'd1;
            end
            tne_next  = 1'b0;
            mode_next = ctt_pkg::MODE_GAP;
          end else begin
            if (!del) begin
              lst[0] = '{ctt_pkg::K_BYTE, c}; n = 2'd1;
              tne_next = 1'b1;
            end
            drop = 1'b1;
          end
        end
        ctt_pkg::MODE_QUOTE: begin
          drop = 1'b1;
          if (c == oq && !esc) begin
            if (!cfg.strip_quotes) begin
              lst[n] = '{ctt_pkg::K_BYTE, c}; n = n + 1'b1;
            end
            lst[n] = '{ctt_pkg::K_END, 8'd0}; n = n + 1'b1;
            mode_next = ctt_pkg::MODE_GAP;
            oq_next   = 8'd0;
          end else if (cfg.strip_quotes) begin
            esc_next = (c == ctt_pkg::ESC_BYTE);
            if (esc && c != oq) begin
              lst[n] = '{ctt_pkg::K_BYTE, ctt_pkg::ESC_BYTE}; n = n + 1'b1;
            end
            if (c != ctt_pkg::ESC_BYTE) begin
              lst[n] = '{ctt_pkg::K_BYTE, c}; n = n + 1'b1;
            end
          end else begin
            lst[0]   = '{ctt_pkg::K_BYTE, c}; n = 2'd1;
            esc_next = (c == ctt_pkg::ESC_BYTE);
          end
        end
        default: begin
          drop = 1'b1;
          if (close_here) begin
            csc_next  = len_close - 1'b1;
            mode_next = ctt_pkg::MODE_GAP;
          end
        end
      endcase
    end
  end

  assign text_in.ready = !flush && ((fill < FW'(COMMENT_MAX)) || (step && drop));
  assign accept        = text_in.valid && text_in.ready;

  // window shift and append
  always_comb begin
    logic [FW-1:0] f;
    for (int i = 0; i < COMMENT_MAX; i++) win_next[i] = win[i];
    f = fill;
    if (step && drop) begin
      for (int i = 0; i < COMMENT_MAX - 1; i++) win_next[i] = win[i+1];
      win_next[COMMENT_MAX-1] = 8'd0;
      f = fill - 1'b1;
    end
    if (accept) begin
      win_next[f[IW-1:0]] = text_in.text_byte;
      f = f + 1'b1;
    end
    fill_next = f;
  end

  assign push.valid = (work || fin) && room;
  assign push.cnt   = n;
  assign push.list  = lst;

  always_ff @(posedge clk) begin
    win <= win_next;
    if (rst || (fin && room)) begin
      fill  <= '0;
      flush <= 1'b0;
      mode  <= ctt_pkg::MODE_GAP;
      oq    <= 8'd0;
      esc   <= 1'b0;
      tne   <= 1'b0;
      csc   <= '0;
    end else begin
      fill <= fill_next;
      if (accept) flush <= text_in.end_of_text;
      if (step) begin
        mode <= mode_next;
        oq   <= oq_next;
        esc  <= esc_next;
        tne  <= tne_next;
        csc  <= csc_next;
      end
    end
  end

endmodule

FILE: rtl/ctt_outq.sv
// ----------------------------------------------------------------------------
// ctt_outq
// Pending result line and output register, one result per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module ctt_outq (
  input  logic           clk,
  input  logic           rst,
  input  ctt_pkg::push_t push,
  output logic           room,
  ctt_token_if.source    token_out
);

  ctt_pkg::res_list_t            pend;
  logic [ctt_pkg::RES_CNT_W-1:0] cnt;
  logic                          ov;
  ctt_pkg::res_t                 oreg;
  logic                          pop;

  assign pop  = (cnt != '0) && (!ov || token_out.ready);
  assign room = (cnt == '0) || (cnt == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ov  <= 1'b0;
    end else begin
      if (push.valid) begin
        pend <= push.list;
        cnt  <= push.cnt;
      end else if (pop) begin
        for (int i = 0; i < ctt_pkg::RES_MAX - 1; i++) pend[i] <= pend[i+1];
        cnt <= cnt - 1'b1;
      end
      if (pop) begin
        ov   <= 1'b1;
        oreg <= pend[0];
      end else if (token_out.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign token_out.valid      = ov;
  assign token_out.kind       = oreg.kind;
  assign token_out.token_byte = oreg.data;

endmodule

FILE: rtl/configurable_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// configurable_text_tokenizer_top
// Byte stream lexer: splitters, comments, delete set, specials, quotes.
// ----------------------------------------------------------------------------
// a byte is decided once the window holds COMMENT_MAX bytes (or at end of text)
// throughput: one byte per cycle while the output queue has room; a byte that ends
// a plain token is rescanned in gap mode; output: at most one result per cycle
// end of text drains the window at the same rate, then emits the closing results
// reset clears scan state and the window fill, strip_quotes to 1, other cfg to 0
module configurable_text_tokenizer_top #(
  parameter int SET_SLOTS   = ctt_pkg::SET_SLOTS_DEF,
  parameter int COMMENT_MAX = ctt_pkg::COMMENT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ctt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctt_pkg::CFG_W-1:0]     cfg_data,
  ctt_text_if.sink                      text_in,
  ctt_token_if.source                   token_out
);

  ctt_pkg::cfg_t  cfg;
  ctt_pkg::push_t push;
  logic           room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg              <= '0;
      cfg.strip_quotes <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ctt_pkg::CFG_SPLITTER:      cfg.splitter_set  <= cfg_data;
        ctt_pkg::CFG_SPECIAL:       cfg.special_set   <= cfg_data;
        ctt_pkg::CFG_QUOTE:         cfg.quote_set     <= cfg_data;
        ctt_pkg::CFG_DELETE:        cfg.erase_set     <= cfg_data;
        ctt_pkg::CFG_COMMENT_OPEN:  cfg.comment_open  <= cfg_data;
        ctt_pkg::CFG_COMMENT_CLOSE: cfg.comment_close <= cfg_data;
        ctt_pkg::CFG_STRIP:         cfg.strip_quotes  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ctt_scan #(
    .SET_SLOTS   (SET_SLOTS),
    .COMMENT_MAX (COMMENT_MAX)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .text_in (text_in),
    .room    (room),
    .push    (push)
  );

  ctt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .token_out (token_out)
  );

endmodule
